// ----- sv/rrmd_pkg.sv -----
`timescale 1ns / 1ps

package rrmd_pkg;

    localparam int BUTTON_COUNT = 10;
    localparam int BTN_W        = 10;
    localparam int LEN_W        = 4;
    localparam int S_TDATA_W    = 40;   // len + four bytes, padded to whole bytes
    localparam int M_TDATA_W    = 24;   // mode + pressed + clicks, padded

    // Buttons that exist; anything above BUTTON_COUNT is masked away.
    localparam logic [BTN_W-1:0] BUTTON_MASK =
        BTN_W'(((64'd1 << BUTTON_COUNT) - 64'd1) & 64'h3FF);

    typedef enum logic [2:0] {
        MODE_UNSET   = 3'd0,
        MODE_A       = 3'd1,
        MODE_B       = 3'd2,
        MODE_C       = 3'd3,
        MODE_D       = 3'd4
    } mode_t;

    localparam logic [BTN_W-1:0] BTN_A     = 10'h001;
    localparam logic [BTN_W-1:0] BTN_B     = 10'h002;
    localparam logic [BTN_W-1:0] BTN_C     = 10'h004;
    localparam logic [BTN_W-1:0] BTN_D     = 10'h008;
    localparam logic [BTN_W-1:0] BTN_L1    = 10'h010;
    localparam logic [BTN_W-1:0] BTN_L2    = 10'h020;
    localparam logic [BTN_W-1:0] BTN_UP    = 10'h040;
    localparam logic [BTN_W-1:0] BTN_DOWN  = 10'h080;
    localparam logic [BTN_W-1:0] BTN_LEFT  = 10'h100;
    localparam logic [BTN_W-1:0] BTN_RIGHT = 10'h200;
    localparam logic [BTN_W-1:0] BTN_DIRS  = BTN_UP | BTN_DOWN | BTN_LEFT | BTN_RIGHT;
    localparam logic [BTN_W-1:0] BTN_ALL   = 10'h3FF;

    // Report byte values
    localparam logic [7:0] RPT_NONE    = 8'h00;
    localparam logic [7:0] RPT_01      = 8'h01;
    localparam logic [7:0] RPT_02      = 8'h02;
    localparam logic [7:0] RPT_04      = 8'h04;
    localparam logic [7:0] RPT_08      = 8'h08;
    localparam logic [7:0] RPT_10      = 8'h10;
    localparam logic [7:0] RPT_20      = 8'h20;
    localparam logic [7:0] RPT_40      = 8'h40;
    localparam logic [7:0] RPT_60      = 8'h60;
    localparam logic [7:0] RPT_80      = 8'h80;
    localparam logic [7:0] RPT_90      = 8'h90;
    localparam logic [7:0] RPT_KEY     = 8'h50;
    localparam logic [7:0] RPT_KEY_A   = 8'h52;
    localparam logic [7:0] RPT_KEY_C   = 8'h51;
    localparam logic [7:0] AXIS_NEG    = 8'hE4;
    localparam logic [7:0] AXIS_POS    = 8'h1C;

    localparam logic [LEN_W-1:0] LEN_ONE  = 4'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 4'd2;
    localparam logic [LEN_W-1:0] LEN_FOUR = 4'd4;

    // Direction of an unambiguous two-byte joystick report, zero if none.
    function automatic logic [BTN_W-1:0] joy_dir(input logic [7:0] b0, input logic [7:0] b1);
        logic [BTN_W-1:0] dir;
        dir = '0;
        if (b0 == RPT_NONE) begin
            case (b1)
                RPT_10:  dir = BTN_UP;
                RPT_90:  dir = BTN_DOWN;
                RPT_40:  dir = BTN_LEFT;
                RPT_60:  dir = BTN_RIGHT;
                default: dir = '0;
            endcase
        end
        return dir;
    endfunction

endpackage

// ----- sv/remote_report_mode_decoder.sv -----
`timescale 1ns / 1ps

// Remote report mode decoder.
// Slave channel (s_): one transfer per remote report or disconnect event.
//   s_tuser is the operation (0 decode a report, 1 disconnect); s_tdata holds
//   the report length and up to four report bytes.
// Master channel (m_): exactly one transfer per accepted input, carrying the
//   guessed mode, the pressed-button bitmap, the clicks raised by that report
//   and, in m_tuser, a flag for a report that matched no rule of the mode.
// Latency: the result is valid the cycle after the input transfer.
// Throughput: one report per cycle while m_tready stays high. Mode detection,
//   table decode and the button update are combinational byte compares and
//   masking between the slave handshake and the state/result registers.
// Reset (aresetn low, synchronous): mode goes to unknown, all buttons are
//   released and no result is pending.
// Stall: while a result waits on m_tready, s_tready is low and the state is
//   held; the held result and the state always describe the same report, and
//   a new input is taken in the same cycle the pending result leaves.
module remote_report_mode_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [3:0] report_length, [11:4] byte_zero, [19:12] byte_one,
    // [27:20] byte_two, [35:28] byte_three, [39:36] zero
    input  logic [rrmd_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] operation
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] mode_now, [12:3] pressed_bits, [22:13] click_bits, [23] zero
    output logic [rrmd_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] unexpected_report
    output logic                              m_tuser
);
    import rrmd_pkg::*;

    mode_t            mode_reg,    mode_next;
    logic [BTN_W-1:0] pressed_reg, pressed_next;
    logic [BTN_W-1:0] click_reg,   click_next;
    logic             bad_reg,     bad_next;
    logic             m_tvalid_reg;

    logic             s_accept;
    logic [LEN_W-1:0] len;
    logic [7:0]       b0, b1, b2, b3;

    // Scratch values of the decode
    mode_t            detected;
    mode_t            mode_dec;
    logic [BTN_W-1:0] base, on, off, clk;
    logic             bad;
    logic             len1, len2, len4, rest_zero;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign len = s_tdata[3:0];
    assign b0  = s_tdata[11:4];
    assign b1  = s_tdata[19:12];
    assign b2  = s_tdata[27:20];
    assign b3  = s_tdata[35:28];

    assign len1 = (len == LEN_ONE);
    assign len2 = (len == LEN_TWO);
    assign len4 = (len == LEN_FOUR);
    assign rest_zero = (b1 == RPT_NONE) && (b2 == RPT_NONE) && (b3 == RPT_NONE);

    // Mode detection: a report unique to one mode switches to it; otherwise
    // a report that contradicts the current mode drops back to unknown.
    always_comb begin
        detected = mode_reg;
        if (len4) begin
            detected = MODE_D;
        end else if (len1) begin
            if (b0 == RPT_04 || b0 == RPT_10 || b0 == RPT_20) begin
                detected = MODE_A;
            end
        end else if (len2) begin
            if ((b0 == RPT_10 && b1 == RPT_KEY_A) || (b0 == RPT_08 && b1 == RPT_KEY_C) ||
                (b0 == RPT_80 && b1 == RPT_KEY)   || (b0 == RPT_40 && b1 == RPT_KEY)) begin
                detected = MODE_B;
            end
        end

        mode_dec = detected;
        if (detected == mode_reg) begin
            case (mode_reg)
                MODE_A: begin
                    if (len2 && ((b0 == RPT_01 && b1 == RPT_KEY) || joy_dir(b0, b1) != '0)) begin
                        mode_dec = MODE_UNSET;
                    end
                end
                MODE_B: begin
                    if (len1 && (b0 == RPT_02 || b0 == RPT_01)) begin
                        mode_dec = MODE_UNSET;
                    end
                end
                MODE_C: begin
                    if ((len1 && b0 == RPT_01) ||
                        (len2 && (b0 == RPT_01 || b0 == RPT_02) && b1 == RPT_KEY)) begin
                        mode_dec = MODE_UNSET;
                    end
                end
                MODE_D: begin
                    if (len2 && joy_dir(b0, b1) != '0) begin
                        mode_dec = MODE_UNSET;
                    end
                end
                default: mode_dec = mode_reg;
            endcase
        end
    end

    // Table decode in the (possibly new) mode; a mode change clears buttons.
    always_comb begin
        base = (mode_dec != mode_reg) ? '0 : pressed_reg;
        on   = '0;
        off  = '0;
        clk  = '0;
        bad  = 1'b0;
        case (mode_dec)
            MODE_A: begin
                if (len1) begin
                    case (b0)
                        RPT_NONE: off = BTN_A | BTN_C | BTN_D | BTN_DIRS;
                        RPT_01: begin
                            on  = BTN_D | BTN_UP;
                            clk = BTN_D;
                        end
                        RPT_02: begin
                            on  = BTN_C | BTN_DOWN;
                            clk = BTN_C;
                        end
                        RPT_04: begin
                            on  = BTN_A;
                            clk = BTN_A;
                        end
                        RPT_10:  on  = BTN_LEFT;
                        RPT_20:  on  = BTN_RIGHT;
                        default: bad = 1'b1;
                    endcase
                end else if (len2 && b1 == RPT_KEY && b0 == RPT_NONE) begin
                    off = BTN_L1;
                end else if (len2 && b1 == RPT_KEY && b0 == RPT_02) begin
                    on  = BTN_L1;
                    clk = BTN_L1;
                end else begin
                    bad = 1'b1;
                end
            end
            MODE_B: begin
                if (!len2) begin
                    bad = 1'b1;
                end else if (b0 == RPT_NONE && b1 == RPT_KEY) begin
                    off = BTN_ALL;
                end else if (b0 == RPT_10 && b1 == RPT_KEY_A) begin
                    on = BTN_A;
                end else if (b0 == RPT_01 && b1 == RPT_KEY) begin
                    on = BTN_B;
                end else if (b0 == RPT_08 && b1 == RPT_KEY_C) begin
                    on = BTN_C;
                end else if (b0 == RPT_02 && b1 == RPT_KEY) begin
                    on = BTN_D;
                end else if (b0 == RPT_80 && b1 == RPT_KEY) begin
                    on = BTN_L1;
                end else if (b0 == RPT_40 && b1 == RPT_KEY) begin
                    on = BTN_L2;
                end else if (joy_dir(b0, b1) != '0) begin
                    on = joy_dir(b0, b1);
                end else begin
                    bad = 1'b1;
                end
            end
            MODE_C: begin
                if (len1 && b0 == RPT_NONE) begin
                    off = BTN_C;
                end else if (len1 && b0 == RPT_02) begin
                    on  = BTN_C;
                    clk = BTN_C;
                end else if (len2 && b0 == RPT_NONE && b1 == RPT_KEY) begin
                    off = BTN_DIRS;
                end else if (len2 && joy_dir(b0, b1) != '0) begin
                    on = joy_dir(b0, b1);
                end else begin
                    bad = 1'b1;
                end
            end
            MODE_D: begin
                if (len1) begin
                    case (b0)
                        RPT_NONE: off = BTN_C | BTN_D;
                        RPT_01: begin
                            on  = BTN_C;
                            clk = BTN_C;
                        end
                        RPT_02: begin
                            on  = BTN_D;
                            clk = BTN_D;
                        end
                        default: bad = 1'b1;
                    endcase
                end else if (len2) begin
                    if (b0 == RPT_NONE && b1 == RPT_KEY) begin
                        off = BTN_A | BTN_B;
                    end else if (b0 == RPT_01 && b1 == RPT_KEY) begin
                        on = BTN_A;
                    end else if (b0 == RPT_02 && b1 == RPT_KEY) begin
                        on = BTN_B;
                    end else begin
                        bad = 1'b1;
                    end
                end else if (len4) begin
                    if (rest_zero && b0 == RPT_NONE) begin
                        off = BTN_L1 | BTN_L2 | BTN_DIRS;
                    end else if (rest_zero && b0 == RPT_02) begin
                        on  = BTN_L1;
                        clk = BTN_L1;
                    end else if (rest_zero && b0 == RPT_01) begin
                        on  = BTN_L2;
                        clk = BTN_L2;
                    end else begin
                        // Axis report: L2 follows byte zero, one direction wins
                        if (b0 == RPT_01) begin
                            on = BTN_L2;
                        end else begin
                            off = BTN_L2;
                        end
                        if (b1 == AXIS_NEG) begin
                            on  = on | BTN_LEFT;
                            off = off | (BTN_DIRS & ~BTN_LEFT);
                        end else if (b1 == AXIS_POS) begin
                            on  = on | BTN_RIGHT;
                            off = off | (BTN_DIRS & ~BTN_RIGHT);
                        end else if (b2 == AXIS_NEG) begin
                            on  = on | BTN_UP;
                            off = off | (BTN_DIRS & ~BTN_UP);
                        end else if (b2 == AXIS_POS) begin
                            on  = on | BTN_DOWN;
                            off = off | (BTN_DIRS & ~BTN_DOWN);
                        end else begin
                            bad = 1'b1;
                        end
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                // Unknown mode: drop everything, only a joystick report presses
                base = '0;
                if (len2) begin
                    on = joy_dir(b0, b1);
                end
            end
        endcase
    end

    // Disconnect resets state; otherwise apply the decode.
    always_comb begin
        if (s_tuser) begin
            mode_next    = MODE_UNSET;
            pressed_next = '0;
            click_next   = '0;
            bad_next     = 1'b0;
        end else begin
            mode_next    = mode_dec;
            pressed_next = ((base & ~off) | on) & BUTTON_MASK;
            click_next   = clk & BUTTON_MASK;
            bad_next     = bad;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_UNSET;
            pressed_reg  <= '0;
            click_reg    <= '0;
            bad_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                mode_reg     <= mode_next;
                pressed_reg  <= pressed_next;
                click_reg    <= click_next;
                bad_reg      <= bad_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, click_reg, pressed_reg, mode_reg};
    assign m_tuser  = bad_reg;

    // A click is always for a button that is pressed in the same result.
    a_click_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((click_reg & ~pressed_reg) == '0))
        else $error("click reported for a released button");

    // Unknown mode never raises clicks or flags a report.
    a_unknown_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && mode_reg == MODE_UNSET) |-> (click_reg == '0 && !bad_reg))
        else $error("unknown mode produced a click or unexpected flag");

    // A disconnect leaves unknown mode with all buttons released.
    a_disconnect: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser) |=> (m_tvalid && mode_reg == MODE_UNSET &&
                                   pressed_reg == '0))
        else $error("disconnect did not clear state");

    // State only moves on an input transfer.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |=> ($stable(mode_reg) && $stable(pressed_reg)))
        else $error("state changed without an input transfer");

endmodule
